// ===== hdl/mh2_pkg.sv =====
// Package for the MurmurHash2 block: constants, sequencer state and
// controller/datapath command and status types. No dependencies.
package mh2_pkg;

  localparam logic [31:0] MixMult   = 32'h5bd1_e995;
  localparam int unsigned KeyShift  = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;
  localparam logic [31:0] SeedReset = 32'hdead_beef;

  // input tdata layout, lowest bit first
  localparam int unsigned InDataW   = 72;
  localparam int unsigned WordLsb   = 0;
  localparam int unsigned VbLsb     = 32;
  localparam int unsigned LenLsb    = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY1,
    ST_KEY2,
    ST_HMIX,
    ST_TAIL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY1,
    OP_KEY2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN
  } mul_op_e;

  typedef struct packed {
    logic    load;
    mul_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_tail;
    logic in_last;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [31:0] tail_mask(input logic [1:0] n);
    logic [31:0] m;
    case (n)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      default: m = 32'h00ff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/mh2_ctrl.sv =====
// Sequencer for the MurmurHash2 block: walks each word through the shared
// multiplier steps. Depends on mh2_pkg.
module mh2_ctrl
  import mh2_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    last_d        = last_q;
    s_axis_tready = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.op      = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          last_d     = sts_i.in_last;
          if (sts_i.in_full) begin
            state_d = ST_KEY1;
          end else if (sts_i.in_tail) begin
            state_d = ST_TAIL;
          end else if (sts_i.in_last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_KEY1: begin
        cmd_o.op = OP_KEY1;
        state_d  = ST_KEY2;
      end
      ST_KEY2: begin
        cmd_o.op = OP_KEY2;
        state_d  = ST_HMIX;
      end
      ST_HMIX: begin
        cmd_o.op = OP_HMIX;
        state_d  = last_q ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = OP_TAIL;
        state_d  = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_full_to_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && sts_i.in_full) |=> state_q == ST_KEY1)
    else $error("full word did not start key mix");

  a_mid_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HMIX && !last_q) |=> state_q == ST_IDLE)
    else $error("non-last word did not return to idle");
`endif

endmodule

// ===== hdl/mh2_dp.sv =====
// Datapath for the MurmurHash2 block: hash, key and seed registers, one
// shared 32x32 constant multiplier and the output register. Depends on mh2_pkg.
module mh2_dp
  import mh2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o
);

  logic [31:0] seed_q;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] w_q;
  logic [1:0]  n_q;
  logic [31:0] out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] in_word, in_len;
  logic [2:0]  in_vb;
  logic [31:0] mul_a, prod;

  assign in_word = s_axis_tdata[WordLsb +: 32];
  assign in_vb   = s_axis_tdata[VbLsb +: 3];
  assign in_len  = s_axis_tdata[LenLsb +: 32];

  assign sts_o.in_full  = in_vb[2];
  assign sts_o.in_tail  = !in_vb[2] && (in_vb[1:0] != 2'd0);
  assign sts_o.in_last  = s_axis_tlast;
  assign sts_o.out_busy = out_valid_q && !m_axis_tready;

  always_comb begin
    case (cmd_i.op)
      OP_KEY1: mul_a = w_q;
      OP_KEY2: mul_a = k_q ^ (k_q >> KeyShift);
      OP_HMIX: mul_a = h_q;
      OP_TAIL: mul_a = h_q ^ (w_q & tail_mask(n_q));
      OP_FIN:  mul_a = h_q ^ (h_q >> FinShiftA);
      default: mul_a = h_q;
    endcase
  end

  assign prod = mul_a * MixMult;

  always_comb begin
    h_d         = h_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (cmd_i.load) begin
      h_d = s_axis_tuser ? (seed_q ^ in_len) : h_q;
    end
    case (cmd_i.op)
      OP_KEY1, OP_KEY2: k_d = prod;
      OP_HMIX:          h_d = prod ^ k_q;
      OP_TAIL:          h_d = prod;
      OP_FIN: begin
        out_d       = prod ^ (prod >> FinShiftB);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    out_q <= out_d;
    if (cmd_i.load) begin
      w_q <= in_word;
      n_q <= in_vb[1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |-> !(out_valid_q && !m_axis_tready))
    else $error("final mix overwrote a pending result");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == OP_FIN))
    else $error("result appeared without a final mix");
`endif

endmodule

// ===== hdl/murmur2_hash32.sv =====
// Top level of the 32-bit MurmurHash2 streaming hasher.
// Instantiates mh2_ctrl and mh2_dp; depends on mh2_pkg.
//
// Hashes a byte message sent as little-endian 32-bit words, one transfer per
// word; tlast marks the final word and tuser the first. One shared 32x32
// multiplier, whose product is registered, does all the work: a full word
// is accepted and then takes three multiply steps (KEY1, KEY2, HMIX), a 1-3
// byte tail takes the TAIL step and an empty word none after the accept; the
// final word adds the finalizer multiply (FIN). The hash sits in an output
// register, and the next word is accepted while it waits to be taken. The
// user writes the seed through cfg_we_i/cfg_wdata_i only while the block is
// idle (the block does not enforce this); the seed resets to 0xDEADBEEF.
module murmur2_hash32
  import mh2_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] data_word, [34:32] valid_bytes, [66:35] total_length, [71:67] zero
  input  logic [InDataW-1:0] s_axis_tdata,
  // [0] first_word
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] hash_value
  output logic [31:0]        m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mh2_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mh2_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== bench/murmur2_hash32_tb.sv =====
// Self-checking testbench for murmur2_hash32: streams messages as word
// transfers, predicts each hash locally and compares it with the output.
// Depends on mh2_pkg and the murmur2_hash32 RTL.
module murmur2_hash32_tb;
  import mh2_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HASH_MULT   = 32'h5bd1_e995;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 20;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [31:0]        cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;

  // local copy of the hasher state
  logic [31:0] seed_reg  = 32'hdead_beef;
  logic [31:0] run_hash  = '0;
  logic [31:0] hash_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rx_stall     = 0;
  bit          gaps_on      = 1'b0;

  murmur2_hash32 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("murmur2_hash32: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // hash arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mix_full(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * HASH_MULT;
    k = k ^ (k >> 24);
    k = k * HASH_MULT;
    return (h * HASH_MULT) ^ k;
  endfunction

  function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [31:0] w,
                                           input logic [2:0] nbytes);
    logic [31:0] keep;
    keep = (nbytes == 3'd1) ? 32'h0000_00ff :
           (nbytes == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
    return (h ^ (w & keep)) * HASH_MULT;
  endfunction

  function automatic logic [31:0] fin_mix(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 13);
    x = x * HASH_MULT;
    return x ^ (x >> 15);
  endfunction

  // advance the local hash by one accepted word, queue the hash on tlast
  function automatic void absorb_word(input logic [31:0] w, input logic [2:0] nbytes,
                                      input logic first, input logic last,
                                      input logic [31:0] len);
    logic [31:0] h;
    h = first ? (seed_reg ^ len) : run_hash;
    if (nbytes >= 3'd4) h = mix_full(h, w);
    else if (nbytes != 3'd0) h = mix_tail(h, w, nbytes);
    run_hash = h;
    if (last) hash_q.push_back(fin_mix(h));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hash_q.size() == 0) begin
        $error("unexpected hash transfer: hash_value = %h", m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = hash_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("hash_value: expected %h, got %h", want, m_axis_tdata);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // word side
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w, input logic [2:0] nbytes,
                           input logic first, input logic last, input logic [31:0] len);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, len, nbytes, w};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_word(w, nbytes, first, last, len);
    if (!(nbytes == 3'd0 && !first && !last)) items_sent++;
  endtask

  // stop sending and wait for every pending hash
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (hash_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain();
    // words after the last tlast may still be in the multiplier
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    seed_reg = value;
    cfg_we_i <= 1'b0;
  endtask

  // well-formed message with random content; length sometimes wrong
  task automatic send_message();
    int unsigned nfull;
    int unsigned tail;
    logic [31:0] len;
    logic [2:0]  nbytes;
    nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    tail  = $urandom_range(0, 3);
    len   = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(nfull * 4 + tail);
    if (nfull == 0 && tail == 0) begin
      send_word($urandom(), 3'd0, 1'b1, 1'b1, len);
    end else begin
      for (int i = 0; i < nfull; i++) begin
        nbytes = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
        send_word($urandom(), nbytes, i == 0, tail == 0 && i == nfull - 1, len);
      end
      if (tail != 0) send_word($urandom(), 3'(tail), nfull == 0, 1'b1, len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // words before any first mark chain from the zero reset state
  task automatic test_no_first();
    send_word(32'h0123_4567, 3'd4, 1'b0, 1'b0, 32'hffff_ffff);
    send_word(32'hffff_ffff, 3'd0, 1'b0, 1'b1, 32'h0);
  endtask

  task automatic test_empty();
    send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'h0);
    send_word(32'h0, 3'd0, 1'b1, 1'b1, 32'hffff_ffff);
  endtask

  task automatic test_tails();
    send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1);
    send_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 32'd2);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
  endtask

  // full words, including byte counts above four; the first message ends in a three-byte tail
  task automatic test_full_words();
    send_word(32'h0, 3'd4, 1'b1, 1'b0, 32'd11);
    send_word(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'd11);
    send_word(32'h8000_0001, 3'd3, 1'b0, 1'b1, 32'd11);
    send_word(32'hdead_beef, 3'd5, 1'b1, 1'b0, 32'd12);
    send_word(32'h1234_5678, 3'd6, 1'b0, 1'b0, 32'd12);
    send_word(32'hcafe_f00d, 3'd7, 1'b0, 1'b1, 32'd12);
  endtask

  // partial and empty words mid-stream, then continuing past tlast
  task automatic test_mid_stream();
    send_word(32'haaaa_5555, 3'd4, 1'b1, 1'b0, 32'd9);
    send_word(32'h5555_aaaa, 3'd2, 1'b0, 1'b0, 32'd9);
    send_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'd9);
    send_word(32'h0f0f_0f0f, 3'd4, 1'b0, 1'b1, 32'd9);
    send_word(32'h7777_7777, 3'd4, 1'b0, 1'b1, 32'd0);
    send_word(32'h0000_00ff, 3'd1, 1'b0, 1'b0, 32'd0);
    send_word(32'h0, 3'd0, 1'b0, 1'b1, 32'd0);
  endtask

  task automatic test_random(input int unsigned count, input bit with_gaps);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 39) == 0) drain();
      if ($urandom_range(0, 6) == 0) begin
        send_word($urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom());
      end else begin
        send_message();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gaps_on = 1'b1;
    test_no_first();
    test_empty();
    test_tails();
    test_full_words();
    test_mid_stream();

    write_seed(32'h0);
    test_random(300, 1'b1);
    write_seed(32'hffff_ffff);
    test_random(300, 1'b1);
    write_seed($urandom());
    test_random(400, 1'b1);
    write_seed($urandom());
    test_random(300, 1'b1);
    gaps_on = 1'b0;
    test_random(200, 1'b0);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && hash_q.size() == 0) begin
      $display("murmur2_hash32: match");
    end else begin
      if (hash_q.size() != 0) $error("%0d hash transfers never arrived", hash_q.size());
      $display("murmur2_hash32: mismatch");
    end
    $finish;
  end

endmodule
